// File: rtl/jeo_pkg.sv
// jeo_pkg: shared types, opcodes and sizes for the JVM extended-op executor.
// No dependencies; imported by every module in rtl/.
package jeo_pkg;

    localparam int LOCAL_SLOTS = 256;
    localparam int STACK_DEPTH = 64;
    localparam int LAW = $clog2(LOCAL_SLOTS);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int LIW = 9;
    localparam int IXW = 17;

    localparam logic [7:0] OP_WIDE      = 8'hc4;
    localparam logic [7:0] OP_MULTIANEW = 8'hc5;
    localparam logic [7:0] OP_IFNULL    = 8'hc6;
    localparam logic [7:0] OP_IFNONNULL = 8'hc7;
    localparam logic [7:0] OP_GOTO_W    = 8'hc8;
    localparam logic [7:0] OP_JSR_W     = 8'hc9;

    localparam logic [7:0] SUB_LOAD_LO  = 8'h15;
    localparam logic [7:0] SUB_LOAD_HI  = 8'h19;
    localparam logic [7:0] SUB_STORE_LO = 8'h36;
    localparam logic [7:0] SUB_STORE_HI = 8'h3a;
    localparam logic [7:0] SUB_RET      = 8'ha9;
    localparam logic [7:0] SUB_IINC     = 8'h84;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNSUP     = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_LOCAL_OOR = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        K_LOAD, K_STORE, K_RET, K_IINC, K_IFNULL, K_IFNONNULL, K_GOTO, K_JSR, K_UNSUP
    } kind_t;

    typedef struct packed {
        logic [7:0] func;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] next_pc;
        logic [6:0]  stack_count;
        logic [63:0] top_value;
    } out_word_t;

    typedef struct packed {
        kind_t       kind;
        logic        idx_err;
        logic [15:0] idx;
        logic [31:0] imm;
    } op_t;

endpackage

// File: rtl/jeo_decode.sv
// jeo_decode: classifies an input word into an op record and checks the local index.
// Depends on jeo_pkg.
module jeo_decode (
    input  jeo_pkg::in_word_t  in_word,
    input  logic [8:0]         locals_in_use,
    output jeo_pkg::op_t       op
);
    import jeo_pkg::*;

    logic [15:0] idx;
    logic [31:0] off32;
    logic [31:0] br16;
    logic [31:0] cst16;
    logic        idx_ok;

    assign idx   = {in_word.byte2, in_word.byte3};
    assign off32 = {in_word.byte1, in_word.byte2, in_word.byte3, in_word.byte4};
    assign br16  = {{16{in_word.byte1[7]}}, in_word.byte1, in_word.byte2};
    assign cst16 = {{16{in_word.byte4[7]}}, in_word.byte4, in_word.byte5};
    assign idx_ok = (IXW'(idx) < IXW'(locals_in_use)) && (IXW'(idx) < IXW'(LOCAL_SLOTS));

    always_comb begin
        op.idx     = idx;
        op.idx_err = 1'b0;
        op.imm     = off32;
        op.kind    = K_UNSUP;
        unique case (in_word.func)
            OP_WIDE: begin
                op.idx_err = !idx_ok;
                op.imm     = cst16;
                unique case (in_word.byte1) inside
                    [SUB_LOAD_LO:SUB_LOAD_HI]:   op.kind = K_LOAD;
                    [SUB_STORE_LO:SUB_STORE_HI]: op.kind = K_STORE;
                    SUB_RET:                     op.kind = K_RET;
                    SUB_IINC:                    op.kind = K_IINC;
                    default: begin
                        op.kind    = K_UNSUP;
                        op.idx_err = 1'b0;
                    end
                endcase
            end
            OP_IFNULL: begin
                op.kind = K_IFNULL;
                op.imm  = br16;
            end
            OP_IFNONNULL: begin
                op.kind = K_IFNONNULL;
                op.imm  = br16;
            end
            OP_GOTO_W:    op.kind = K_GOTO;
            OP_JSR_W:     op.kind = K_JSR;
            OP_MULTIANEW: op.kind = K_UNSUP;
            default:      op.kind = K_UNSUP;
        endcase
    end

endmodule

// File: rtl/jeo_queue.sv
// jeo_queue: two-entry queue of decoded ops between front and back.
// Depends on jeo_pkg.
module jeo_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jeo_pkg::op_t  push_op,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output jeo_pkg::op_t  head_op
);
    import jeo_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_op    = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: rtl/jeo_back.sv
// jeo_back: executes ops against pc, local store and operand stack; owns the result register.
// Depends on jeo_pkg.
module jeo_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  jeo_pkg::op_t        q_op,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output jeo_pkg::out_word_t  m_data
);
    import jeo_pkg::*;

    typedef enum logic [1:0] {
        S_READ = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t             state_reg;
    op_t                cur_reg;
    logic [31:0]        pc_reg, pc_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    logic [63:0]        top_reg, top_next;
    status_t            status;
    logic               m_valid_reg;
    out_word_t          m_data_reg;

    logic [63:0]        loc_mem [LOCAL_SLOTS];
    logic [LOCAL_SLOTS-1:0] loc_vld_reg;
    logic [63:0]        loc_rd_reg;
    logic               loc_rv_reg;
    logic [63:0]        lv;
    logic               loc_we;
    logic [63:0]        loc_wd;

    logic [63:0]        stk_mem [STACK_DEPTH];
    logic [63:0]        stk_rd_reg;
    logic               stk_we;
    logic [63:0]        stk_wd;
    logic [63:0]        below_top;

    logic               fire, full, empty, take;
    logic [LAW-1:0]     la;

    assign q_pop = (state_reg == S_READ) && q_valid;
    assign fire  = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);
    assign full  = (sp_reg == SPW'(STACK_DEPTH));
    assign empty = (sp_reg == '0);
    assign lv    = loc_rv_reg ? loc_rd_reg : 64'd0;
    assign below_top = (sp_reg >= SPW'(2)) ? stk_rd_reg : 64'd0;
    assign la    = cur_reg.idx[LAW-1:0];
    assign take  = (top_reg == 64'd0) ^ (cur_reg.kind == K_IFNONNULL);

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            loc_rd_reg <= loc_mem[q_op.idx[LAW-1:0]];
        end
        if (fire && loc_we) begin
            loc_mem[la] <= loc_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            stk_rd_reg <= stk_mem[SAW'(sp_reg - SPW'(2))];
        end
        if (fire && stk_we) begin
            stk_mem[SAW'(sp_reg)] <= stk_wd;
        end
    end

    always_comb begin
        status   = ST_OK;
        pc_next  = pc_reg;
        sp_next  = sp_reg;
        top_next = top_reg;
        loc_we   = 1'b0;
        loc_wd   = top_reg;
        stk_we   = 1'b0;
        stk_wd   = lv;
        if (cur_reg.kind == K_UNSUP) begin
            status = ST_UNSUP;
        end else if (cur_reg.idx_err) begin
            status = ST_LOCAL_OOR;
        end else begin
            case (cur_reg.kind)
                K_LOAD: begin
                    if (full) begin
                        status = ST_OVERFLOW;
                    end else begin
                        stk_we   = 1'b1;
                        top_next = lv;
                        sp_next  = sp_reg + SPW'(1);
                        pc_next  = pc_reg + 32'd4;
                    end
                end
                K_STORE: begin
                    if (empty) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        loc_we   = 1'b1;
                        top_next = below_top;
                        sp_next  = sp_reg - SPW'(1);
                        pc_next  = pc_reg + 32'd4;
                    end
                end
                K_RET: pc_next = lv[31:0];
                K_IINC: begin
                    loc_we  = 1'b1;
                    loc_wd  = {lv[63:32], lv[31:0] + cur_reg.imm};
                    pc_next = pc_reg + 32'd6;
                end
                K_IFNULL, K_IFNONNULL: begin
                    if (empty) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        top_next = below_top;
                        sp_next  = sp_reg - SPW'(1);
                        pc_next  = pc_reg + (take ? cur_reg.imm : 32'd3);
                    end
                end
                K_GOTO: pc_next = pc_reg + cur_reg.imm;
                K_JSR: begin
                    if (full) begin
                        status = ST_OVERFLOW;
                    end else begin
                        stk_we   = 1'b1;
                        stk_wd   = {32'd0, pc_reg + 32'd5};
                        top_next = stk_wd;
                        sp_next  = sp_reg + SPW'(1);
                        pc_next  = pc_reg + cur_reg.imm;
                    end
                end
                default: status = ST_UNSUP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_op;
        end
        if (fire) begin
            m_data_reg.status      <= status;
            m_data_reg.next_pc     <= pc_next;
            m_data_reg.stack_count <= 7'(sp_next);
            m_data_reg.top_value   <= top_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_READ;
            pc_reg      <= '0;
            sp_reg      <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
            loc_vld_reg <= '0;
            loc_rv_reg  <= 1'b0;
        end else begin
            if (q_pop) begin
                loc_rv_reg <= loc_vld_reg[q_op.idx[LAW-1:0]];
            end
            unique case (state_reg)
                S_READ: if (q_valid) state_reg <= S_EXEC;
                S_EXEC: if (fire) state_reg <= S_READ;
                default: state_reg <= S_READ;
            endcase
            if (fire) begin
                pc_reg      <= pc_next;
                sp_reg      <= sp_next;
                top_reg     <= top_next;
                m_valid_reg <= 1'b1;
                if (loc_we) loc_vld_reg[la] <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");
    a_empty_top: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg == '0 |-> top_reg == 64'd0) else $error("nonzero top on empty stack");
    a_pop_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg == S_EXEC) else $error("popped op not executed");
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_EXEC |=> $stable(pc_reg)) else $error("pc changed outside exec");
`endif

endmodule

// File: rtl/jvm_extended_op_execute.sv
// jvm_extended_op_execute: top level of the JVM extended-op executor.
// Depends on jeo_pkg, jeo_decode, jeo_queue, jeo_back.
//
// Usage:
//   s_valid/s_ready/s_data carry one instruction word (opcode plus five bytes).
//   m_valid/m_ready/m_data return one result word per instruction: status,
//   next pc, stack count and top of stack.
//   cfg_valid/cfg_ready/cfg_data write locals_in_use; cfg_ready is always high.
//   Write it only while no instruction is in flight.
// Flow:
//   An accepted word is decoded and queued in the same cycle; the execute unit
//   first reads the local store and stack memory in its read state, then
//   executes and loads the result register in its execute state. It takes a
//   new word from the queue only after the current one has executed, so
//   successive words do not overlap in the execute unit.
// Reset (aresetn low, synchronous): pc 0, stack empty, all locals read as zero,
//   locals_in_use 256, queue empty, no result pending.
// Stall: a result held by a low m_ready stops the execute unit; the two-entry
//   queue then fills and s_ready drops.
module jvm_extended_op_execute (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jeo_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jeo_pkg::out_word_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [8:0]          cfg_data
);
    import jeo_pkg::*;

    logic [LIW-1:0] liu_reg;
    op_t            dec_op, head_op;
    logic           q_full, q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            liu_reg <= LIW'(256);
        end else if (cfg_valid) begin
            liu_reg <= cfg_data;
        end
    end

    jeo_decode u_decode (
        .in_word       (s_data),
        .locals_in_use (liu_reg),
        .op            (dec_op)
    );

    jeo_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid && !q_full),
        .push_op    (dec_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (head_op)
    );

    jeo_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_op    (head_op),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
